// ----- rtl/tpt_pkg.sv -----
package tpt_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int IDX_W           = 12;
  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int OUT_DATA_W      = 64;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd5;

  typedef struct packed {
    logic             too_long;
    logic [IDX_W-1:0] fall_time;
    logic [IDX_W-1:0] rise_time;
    logic [IDX_W-1:0] peak_index;
    logic [IDX_W-1:0] end_index;
    logic             end_found;
    logic [IDX_W-1:0] start_index;
    logic             start_found;
  } result_t;

endpackage

// ----- rtl/tpt_tracker.sv -----
module tpt_tracker
  import tpt_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                last,
  input  logic [SAMPLE_W-1:0] threshold,
  output result_t             result
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_INSIDE,
    PH_ENDED
  } phase_t;

  phase_t              phase, phase_next;
  logic [CNT_W-1:0]    sample_count;
  logic [SAMPLE_W-1:0] baseline, baseline_next;
  logic [IDX_W-1:0]    start_reg, start_next;
  logic [IDX_W-1:0]    end_reg, end_next;
  logic [IDX_W-1:0]    peak_reg, peak_next;
  logic [SAMPLE_W-1:0] peak_height, peak_height_next;
  logic [IDX_W-1:0]    whole_peak, whole_peak_next;
  logic [SAMPLE_W-1:0] whole_height, whole_height_next;
  logic                overflow_flag, overflow_next;
  logic                take;
  logic [IDX_W-1:0]    idx;
  logic [SAMPLE_W-1:0] dev;
  logic                below;
  logic                sf;
  logic                ef;
  logic [IDX_W-1:0]    pk;

  assign take  = sample_count < CNT_W'(MAX_SAMPLES);
  assign idx   = IDX_W'(sample_count);
  assign below = sample < threshold;

  always_comb begin
    baseline_next     = (sample_count == '0) ? sample : baseline;
    dev               = (sample >= baseline_next) ? (sample - baseline_next)
                                                  : (baseline_next - sample);
    phase_next        = phase;
    start_next        = start_reg;
    end_next          = end_reg;
    peak_next         = peak_reg;
    peak_height_next  = peak_height;
    whole_peak_next   = whole_peak;
    whole_height_next = whole_height;
    overflow_next     = overflow_flag | ~take;
    if (take) begin
      if (dev > whole_height) begin
        whole_height_next = dev;
        whole_peak_next   = idx;
      end
      unique case (phase)
        PH_WAIT: begin
          if (below) begin
            start_next       = idx;
            peak_next        = idx;
            peak_height_next = dev;
            phase_next       = PH_INSIDE;
          end
        end
        PH_INSIDE: begin
          if (!below) begin
            end_next   = idx;
            phase_next = PH_ENDED;
          end else if (dev > peak_height) begin
            peak_height_next = dev;
            peak_next        = idx;
          end
        end
        default: begin
        end
      endcase
    end else begin
      baseline_next = baseline;
    end
  end

  always_comb begin
    sf = phase_next != PH_WAIT;
    ef = phase_next == PH_ENDED;
    pk = sf ? peak_next : whole_peak_next;
    result.start_found = sf;
    result.start_index = sf ? start_next : '0;
    result.end_found   = ef;
    result.end_index   = ef ? end_next : '0;
    result.peak_index  = pk;
    result.rise_time   = sf ? (pk - start_next) : '0;
    result.fall_time   = ef ? (end_next - pk) : '0;
    result.too_long    = overflow_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      phase         <= PH_WAIT;
      sample_count  <= '0;
      baseline      <= '0;
      start_reg     <= '0;
      end_reg       <= '0;
      peak_reg      <= '0;
      peak_height   <= '0;
      whole_peak    <= '0;
      whole_height  <= '0;
      overflow_flag <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      if (take) begin
        sample_count <= sample_count + 1'b1;
      end
      baseline      <= baseline_next;
      start_reg     <= start_next;
      end_reg       <= end_next;
      peak_reg      <= peak_next;
      peak_height   <= peak_height_next;
      whole_peak    <= whole_peak_next;
      whole_height  <= whole_height_next;
      overflow_flag <= overflow_next;
    end
  end

endmodule

// ----- rtl/threshold_pulse_timing_top.sv -----
// A waveform's result word is registered once its last sample leaves the input register.
// Throughput: one sample word per cycle; the only stall is a held result word blocking the
// next last sample from leaving the input register.
// Reset: synchronous, active high; clears all waveform state and the valid flags of the word
// registers and sets the threshold to 5. Configuration is accepted in every cycle.
module threshold_pulse_timing_top
  import tpt_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [SAMPLE_W-1:0]   cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // sample
  input  logic [SAMPLE_W-1:0]   s_tdata,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // start_found, start_index, end_found, end_index, peak_index, rise_time, fall_time,
  // too_long, zero fill
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int RES_W = $bits(result_t);

  logic [SAMPLE_W-1:0] threshold;
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s1_last;
  logic                advance;
  logic                out_valid;
  logic [RES_W-1:0]    out_data;
  result_t             result;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!s1_last || !out_valid || m_tready);
  assign s_tready  = !s1_valid || advance;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {{(OUT_DATA_W - RES_W){1'b0}}, out_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_valid) begin
      threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_sample <= s_tdata;
      s1_last   <= s_tlast;
    end
  end

  tpt_tracker #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_tracker (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .sample   (s1_sample),
    .last     (s1_last),
    .threshold(threshold),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      out_data <= result;
    end
  end

endmodule
